### rtl/planar_framebuffer_draw_engine_core_macros.svh
// Assertion macros for the planar frame store draw engine.
// Used by the top level; depends on nothing else.
`ifndef PLANAR_FRAMEBUFFER_DRAW_ENGINE_CORE_MACROS_SVH
`define PLANAR_FRAMEBUFFER_DRAW_ENGINE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PFDE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PFDE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PFDE_ASSERT_IMP(label, clk, rst, ante, cons)
`define PFDE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/pfde_pkg.sv
// Package for the planar frame store draw engine: command codes, sequencer
// states and the plane lane helper. No dependencies.
`timescale 1ns / 1ps
package pfde_pkg;

   // command codes
   localparam logic [1:0] CMD_PLOT  = 2'd0;
   localparam logic [1:0] CMD_FILL  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SETUP,
      ST_PLOT_RD,
      ST_PLOT_WR,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // spread a byte mask into the planes whose color bit is set
   function automatic logic [31:0] color_word(input logic [3:0] color,
                                              input logic [7:0] mask);
      return {color[3] ? mask : 8'h00, color[2] ? mask : 8'h00,
              color[1] ? mask : 8'h00, color[0] ? mask : 8'h00};
   endfunction

endpackage

### rtl/pfde_if.sv
// Channel interfaces of the draw engine: command, result and color register.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps
interface pfde_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [10:0] x_pos;
   logic [10:0] y_pos;
   logic [9:0]  rect_width;
   logic [9:0]  rect_height;
   modport source (output valid, cmd, x_pos, y_pos, rect_width, rect_height,
                   input ready);
   modport sink (input valid, cmd, x_pos, y_pos, rect_width, rect_height,
                 output ready);
endinterface

interface pfde_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [15:0] byte_address;
   logic [7:0]  plane0_byte;
   logic [7:0]  plane1_byte;
   logic [7:0]  plane2_byte;
   logic [7:0]  plane3_byte;
   modport source (output valid, status, byte_address, plane0_byte, plane1_byte,
                   plane2_byte, plane3_byte, input ready);
   modport sink (input valid, status, byte_address, plane0_byte, plane1_byte,
                 plane2_byte, plane3_byte, output ready);
endinterface

interface pfde_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] draw_color;
   modport source (output valid, draw_color, input ready);
   modport sink (input valid, draw_color, output ready);
endinterface

### rtl/planar_framebuffer_draw_engine_core.sv
// Planar frame store draw engine, top level.
// Depends on pfde_pkg, the pfde_*_if interfaces, pfde_ram and the macro header.
//
// Use: commands enter on req_bus (valid/ready), one result leaves on rsp_bus
// for every command, and csr_bus writes the 4-bit drawing color (reset 1),
// to be written only while no command is in flight. Each store word holds one
// byte of each of the four planes; pixel (x, y) is word x/8 + y*row_bytes.
// Plot does a read-modify-write of one word. Fill does a registered read,
// then a write, for each touched word. Clear writes one word a cycle. The
// next command is accepted in the cycle after the result is loaded.
// One command at a time: req_bus.ready is high only while the engine is idle.
// After reset the engine sweeps the store to zero, one word a cycle, and
// accepts no command until done; color writes are taken at any time. The
// result sits in an output register; if the receiver stalls, the next
// command is still accepted and its result waits in the engine until the
// output register frees.
`timescale 1ns / 1ps
`include "planar_framebuffer_draw_engine_core_macros.svh"
module planar_framebuffer_draw_engine_core #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic        clock,
   input  logic        reset,
   pfde_req_if.sink    req_bus,
   pfde_rsp_if.source  rsp_bus,
   pfde_csr_if.sink    csr_bus
);
   import pfde_pkg::*;

   localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
   localparam int DEPTH     = ROW_BYTES * SCREEN_HEIGHT;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam logic [11:0]   WIDTH_12  = 12'(SCREEN_WIDTH);
   localparam logic [11:0]   HEIGHT_12 = 12'(SCREEN_HEIGHT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(ROW_BYTES);

   // control state
   state_type     state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [3:0]    color_ff, color_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // command and working registers
   logic [1:0]    cmd_ff, cmd_in;
   logic [10:0]   x_ff, x_in;
   logic [10:0]   y_ff, y_in;
   logic [9:0]    w_ff, w_in;
   logic [9:0]    h_ff, h_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [CW-1:0] col_first_ff, col_first_in;
   logic [CW-1:0] col_last_ff, col_last_in;
   logic [2:0]    x_lo_ff, x_lo_in;
   logic [2:0]    x_hi_ff, x_hi_in;
   logic [10:0]   cur_row_ff, cur_row_in;
   logic [10:0]   row_last_ff, row_last_in;
   logic          res_status_ff, res_status_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [31:0]   res_word_ff, res_word_in;
   logic          out_status_ff, out_status_in;
   logic [15:0]   out_addr_ff, out_addr_in;
   logic [31:0]   out_word_ff, out_word_in;

   // RAM port signals
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;

   // setup arithmetic
   logic [11:0]   sum_x, sum_y, x_end, y_end, x_end_m1, y_end_m1;
   logic          fill_empty, off_screen;
   logic [7:0]    plot_mask, fill_mask;
   logic [2:0]    mask_lo, mask_hi;
   logic          req_take;

   // terms used by the checks
   logic          chk_fill_sets, chk_zero_result;

   pfde_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // clipping of the rectangle against the screen
   always_comb begin
      sum_x      = 12'(x_ff) + 12'(w_ff);
      sum_y      = 12'(y_ff) + 12'(h_ff);
      x_end      = (sum_x > WIDTH_12) ? WIDTH_12 : sum_x;
      y_end      = (sum_y > HEIGHT_12) ? HEIGHT_12 : sum_y;
      x_end_m1   = x_end - 12'd1;
      y_end_m1   = y_end - 12'd1;
      fill_empty = (12'(x_ff) >= x_end) || (12'(y_ff) >= y_end);
      off_screen = (12'(x_ff) >= WIDTH_12) || (12'(y_ff) >= HEIGHT_12);
   end

   // pixel masks: one bit for plot, a clipped run of bits for fill
   always_comb begin
      plot_mask = 8'h80 >> x_ff[2:0];
      mask_lo   = (cur_col_ff == col_first_ff) ? x_lo_ff : 3'd0;
      mask_hi   = (cur_col_ff == col_last_ff) ? x_hi_ff : 3'd7;
      fill_mask = (8'hFF >> mask_lo) & (8'hFF << (3'd7 - mask_hi));
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // sequencer: next state, RAM control and working registers
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      color_in      = color_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      row_base_in   = row_base_ff;
      addr_in       = addr_ff;
      cur_col_in    = cur_col_ff;
      col_first_in  = col_first_ff;
      col_last_in   = col_last_ff;
      x_lo_in       = x_lo_ff;
      x_hi_in       = x_hi_ff;
      cur_row_in    = cur_row_ff;
      row_last_in   = row_last_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_word_in   = res_word_ff;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      out_word_in   = out_word_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = 32'h0;
      ram_raddr     = row_base_ff + AW'(cur_col_ff);

      if (csr_bus.valid && csr_bus.ready) begin
         color_in = csr_bus.draw_color;
      end
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in   = req_bus.cmd;
               x_in     = req_bus.x_pos;
               y_in     = req_bus.y_pos;
               w_in     = req_bus.rect_width;
               h_in     = req_bus.rect_height;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            row_base_in   = AW'(y_ff * ROW_BYTES);
            cur_col_in    = CW'(x_ff >> 3);
            col_first_in  = CW'(x_ff >> 3);
            col_last_in   = CW'(x_end_m1 >> 3);
            x_lo_in       = x_ff[2:0];
            x_hi_in       = x_end_m1[2:0];
            cur_row_in    = y_ff;
            row_last_in   = 11'(y_end_m1);
            res_status_in = 1'b0;
            res_addr_in   = '0;
            res_word_in   = 32'h0;
            case (cmd_ff)
               CMD_PLOT: begin
                  if (off_screen) begin
                     res_status_in = 1'b1;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_PLOT_RD;
                  end
               end
               CMD_FILL: begin
                  state_in = fill_empty ? ST_DONE : ST_FILL_RD;
               end
               CMD_CLEAR: begin
                  sweep_in = '0;
                  state_in = ST_CLEAR;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_PLOT_RD: begin
            addr_in  = ram_raddr;
            state_in = ST_PLOT_WR;
         end
         ST_PLOT_WR: begin
            ram_we      = 1'b1;
            ram_wdata   = (ram_rdata & ~color_word(4'hF, plot_mask))
                          | color_word(color_ff, plot_mask);
            res_addr_in = addr_ff;
            res_word_in = ram_wdata;
            state_in    = ST_DONE;
         end
         ST_FILL_RD: begin
            addr_in  = ram_raddr;
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | color_word(4'hF, fill_mask);
            state_in  = ST_FILL_RD;
            if (cur_col_ff == col_last_ff) begin
               cur_col_in  = col_first_ff;
               row_base_in = row_base_ff + ROW_STEP;
               cur_row_in  = cur_row_ff + 11'd1;
               if (cur_row_ff == row_last_ff) begin
                  state_in = ST_DONE;
               end
            end else begin
               cur_col_in = cur_col_ff + CW'(1);
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = color_word(color_ff, 8'hFF);
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_DONE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_addr_in   = 16'(res_addr_ff);
               out_word_in   = res_word_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         color_ff     <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      row_base_ff   <= row_base_in;
      addr_ff       <= addr_in;
      cur_col_ff    <= cur_col_in;
      col_first_ff  <= col_first_in;
      col_last_ff   <= col_last_in;
      x_lo_ff       <= x_lo_in;
      x_hi_ff       <= x_hi_in;
      cur_row_ff    <= cur_row_in;
      row_last_ff   <= row_last_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_word_ff   <= res_word_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_word_ff   <= out_word_in;
   end

   // result port
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.byte_address = out_addr_ff;
   assign rsp_bus.plane0_byte  = out_word_ff[7:0];
   assign rsp_bus.plane1_byte  = out_word_ff[15:8];
   assign rsp_bus.plane2_byte  = out_word_ff[23:16];
   assign rsp_bus.plane3_byte  = out_word_ff[31:24];

   // checks
   assign chk_fill_sets   = ((ram_wdata & ram_rdata) == ram_rdata);
   assign chk_zero_result = (out_addr_ff == 16'h0) && (out_word_ff == 32'h0);

   `PFDE_ASSERT_NXT(a_accept_to_setup, clock, reset, req_take, state_ff == ST_SETUP)
   `PFDE_ASSERT_IMP(a_fill_only_sets, clock, reset, state_ff == ST_FILL_WR, chk_fill_sets)
   `PFDE_ASSERT_IMP(a_off_screen_zero, clock, reset, rsp_valid_ff && out_status_ff, chk_zero_result)
endmodule

### rtl/pfde_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module pfde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 38400
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
